// ===== rtl/core/vt4_pkg.sv =====
// Shared types and constants for the 4x4 vertex transform block.
// No dependencies; imported by every module in rtl/core.
package vt4_pkg;

  // Default number of fraction bits of the signed fixed-point format.
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned ELEM_W    = 32;          // one matrix element or vector component
  localparam int unsigned PROD_W    = 2 * ELEM_W;  // exact product of two elements
  localparam int unsigned SUM_W     = PROD_W + 2;  // exact sum of four products
  localparam int unsigned NUM_ELEMS = 16;
  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 6;          // 8-byte stride, eight registers

  // Item kind carried on the slave-side tuser.
  typedef enum logic [1:0] {
    KIND_FULL       = 2'd0,
    KIND_POINT      = 2'd1,
    KIND_ROTATE     = 2'd2,
    KIND_INV_ROTATE = 2'd3
  } kind_e;

  typedef logic [NUM_ELEMS-1:0][ELEM_W-1:0] matrix_t;
  typedef logic [NUM_LANES-1:0][ELEM_W-1:0] vec_t;
  typedef logic [NUM_LANES-1:0][SUM_W-1:0]  sum_vec_t;

  // Load enables for the two register stages inside each lane.
  typedef struct packed {
    logic ld_prod;
    logic ld_sum;
  } lane_ctrl_t;

endpackage

// ===== rtl/core/vertex_transform_4x4_top.sv =====
// Top level of the 4x4 vertex transform: four row lanes and a merging stage.
// Depends on vt4_pkg, vt4_regs, vt4_lane and vt4_merge.
//
// Usage
//   The slave stream carries one vector per word: tdata holds x, y, z, w (32-bit
//   signed fixed point, x lowest) and tuser the item kind (full product, point
//   transform, rotation, inverse rotation). The master stream returns x, y, z, w
//   in tdata and the saturation flag in tuser. The matrix is written through the
//   APB-style port, two elements per 64-bit register at an 8-byte stride, and
//   must only be changed while no word is in flight.
//   Throughput is one word per cycle while the receiver does not stall. The
//   lane multipliers, the four-term sum and the saturating output register each
//   take one register stage.
//   Each stage moves on when the stage after it is empty or moving, so a stalled
//   receiver holds the output word while up to two further words are taken
//   into the empty stages; tready falls only when all three stages are full.
//   Reset empties the pipeline and loads the identity matrix.
module vertex_transform_4x4_top
  import vt4_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [127:0]          s_axis_tdata,  // in_x, in_y, in_z, in_w
  input  logic [1:0]            s_axis_tuser,  // kind
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [127:0]          m_axis_tdata,  // out_x, out_y, out_z, out_w
  output logic                  m_axis_tuser   // saturated
);

  matrix_t    matrix;
  lane_ctrl_t ctrl;
  sum_vec_t   sums;
  vec_t       vec_in;
  vec_t       result;
  kind_e      kind_in;

  logic  prod_vld_q, sum_vld_q, out_vld_q;
  kind_e kind_prod_q, kind_sum_q;
  logic  adv_out, adv_sum, adv_prod, ld_out;

  assign vec_in  = s_axis_tdata;
  assign kind_in = kind_e'(s_axis_tuser);

  // Per-stage advance: a stage may load when it is empty or is being emptied.
  assign adv_out      = !out_vld_q || m_axis_tready;
  assign adv_sum      = !sum_vld_q || adv_out;
  assign adv_prod     = !prod_vld_q || adv_sum;
  assign s_axis_tready = adv_prod;

  assign ctrl.ld_prod = s_axis_tvalid && adv_prod;
  assign ctrl.ld_sum  = prod_vld_q && adv_sum;
  assign ld_out       = sum_vld_q && adv_out;

  // Valid bits and the kind that travels alongside each word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q  <= 1'b0;
      sum_vld_q   <= 1'b0;
      out_vld_q   <= 1'b0;
      kind_prod_q <= KIND_FULL;
      kind_sum_q  <= KIND_FULL;
    end else begin
      if (adv_prod) begin
        prod_vld_q <= s_axis_tvalid;
      end
      if (adv_sum) begin
        sum_vld_q <= prod_vld_q;
      end
      if (adv_out) begin
        out_vld_q <= sum_vld_q;
      end
      if (ctrl.ld_prod) begin
        kind_prod_q <= kind_in;
      end
      if (ctrl.ld_sum) begin
        kind_sum_q <= kind_prod_q;
      end
    end
  end

  vt4_regs #(
    .FRAC_BITS(FRAC_BITS)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .matrix_o(matrix)
  );

  // One lane per result component.
  for (genvar r = 0; r < NUM_LANES; r++) begin : g_lane
    vt4_lane #(
      .FRAC_BITS(FRAC_BITS),
      .ROW      (r)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .kind_i  (kind_in),
      .vec_i   (vec_in),
      .matrix_i(matrix),
      .sum_o   (sums[r])
    );
  end

  vt4_merge #(
    .FRAC_BITS(FRAC_BITS)
  ) u_merge (
    .clk_i      (clk_i),
    .ld_i       (ld_out),
    .kind_i     (kind_sum_q),
    .sums_i     (sums),
    .result_o   (result),
    .saturated_o(m_axis_tuser)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = result;

endmodule

// ===== rtl/core/vt4_regs.sv =====
// Matrix configuration registers behind an APB-style port.
// Depends on vt4_pkg; the matrix resets to the identity.
module vt4_regs
  import vt4_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output matrix_t               matrix_o
);

  localparam logic [ELEM_W-1:0] ONE = ELEM_W'(1) << FRAC_BITS;

  matrix_t               mat_q;
  logic [REG_IDX_W-1:0]  idx;
  logic                  wr_en;

  assign idx   = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;

  // Each register holds two adjacent elements, the even one in the low half.
  // Reset loads the identity: the diagonal elements are one, all others zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ELEMS; i++) begin
        mat_q[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? ONE : '0;
      end
    end else if (wr_en) begin
      mat_q[{idx, 1'b0}] <= pwdata[ELEM_W-1:0];
      mat_q[{idx, 1'b1}] <= pwdata[CFG_DATA_W-1:ELEM_W];
    end
  end

  // Read-back of the addressed pair.
  assign prdata   = {mat_q[{idx, 1'b1}], mat_q[{idx, 1'b0}]};
  assign matrix_o = mat_q;

endmodule

// ===== rtl/core/vt4_lane.sv =====
// One output row of the transform: operand selection, four multipliers and a sum.
// Depends on vt4_pkg; instantiated once per result component.
module vt4_lane
  import vt4_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned ROW       = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lane_ctrl_t      ctrl_i,
  input  kind_e           kind_i,
  input  vec_t            vec_i,
  input  matrix_t         matrix_i,
  output logic [SUM_W-1:0] sum_o
);

  localparam logic [ELEM_W-1:0] ONE = ELEM_W'(1) << FRAC_BITS;

  logic [NUM_LANES-1:0][ELEM_W-1:0] coef;
  logic [NUM_LANES-1:0][ELEM_W-1:0] opnd;
  logic signed [PROD_W-1:0]         prod_d [NUM_LANES];
  logic signed [PROD_W-1:0]         prod_q [NUM_LANES];
  logic signed [SUM_W-1:0]          sum_d;
  logic signed [SUM_W-1:0]          sum_q;

  // Coefficients: a column walk of the matrix, or a row walk for the transpose.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      coef[c] = matrix_i[4*c+ROW];
      opnd[c] = vec_i[c];
    end
    coef[3] = matrix_i[12+ROW];
    opnd[3] = '0;
    unique case (kind_i)
      KIND_FULL: begin
        opnd[3] = vec_i[3];
      end
      KIND_POINT: begin
        opnd[3] = ONE;
      end
      KIND_ROTATE: begin
        opnd[3] = '0;
      end
      KIND_INV_ROTATE: begin
        for (int c = 0; c < 3; c++) begin
          coef[c] = matrix_i[4*ROW+c];
        end
      end
      default: begin
        opnd[3] = '0;
      end
    endcase
  end

  // Exact signed products, one multiplier per column.
  always_comb begin
    for (int c = 0; c < NUM_LANES; c++) begin
      prod_d[c] = $signed(coef[c]) * $signed(opnd[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_prod) begin
      for (int c = 0; c < NUM_LANES; c++) begin
        prod_q[c] <= prod_d[c];
      end
    end
  end

  // Lossless sum of the four products.
  assign sum_d = prod_q[0] + prod_q[1] + prod_q[2] + prod_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.ld_sum) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== rtl/core/vt4_merge.sv =====
// Merging stage: scales and saturates the four lane sums, builds the flag.
// Depends on vt4_pkg; holds the output data register.
module vt4_merge
  import vt4_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     ld_i,
  input  kind_e    kind_i,
  input  sum_vec_t sums_i,
  output vec_t     result_o,
  output logic     saturated_o
);

  localparam int unsigned TOP_LO = ELEM_W - 1 + FRAC_BITS;
  localparam logic [ELEM_W-1:0] MAX_POS = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] MAX_NEG = {1'b1, {(ELEM_W-1){1'b0}}};

  logic [NUM_LANES-1:0]             lane_sat;
  logic [NUM_LANES-1:0][ELEM_W-1:0] lane_res;
  vec_t                             result_d;
  logic                             sat_d;
  vec_t                             result_q;
  logic                             sat_q;

  // Shift right with floor, then clamp when the top bits are not a sign run.
  always_comb begin
    for (int r = 0; r < NUM_LANES; r++) begin
      lane_sat[r] = !((&sums_i[r][SUM_W-1:TOP_LO]) || !(|sums_i[r][SUM_W-1:TOP_LO]));
      if (lane_sat[r]) begin
        lane_res[r] = sums_i[r][SUM_W-1] ? MAX_NEG : MAX_POS;
      end else begin
        lane_res[r] = sums_i[r][TOP_LO:FRAC_BITS];
      end
    end
  end

  // The w component only counts for the full four-component product.
  always_comb begin
    result_d = lane_res;
    sat_d    = lane_sat[0] | lane_sat[1] | lane_sat[2];
    if (kind_i == KIND_FULL) begin
      sat_d = sat_d | lane_sat[3];
    end else begin
      result_d[3] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      result_q <= result_d;
      sat_q    <= sat_d;
    end
  end

  assign result_o    = result_q;
  assign saturated_o = sat_q;

endmodule
